// ===== hw/rtl/flow_line_blocking_departure_sim_core_macros.svh =====
// assertion helpers for the flow line core
`ifndef FLOW_LINE_BLOCKING_DEPARTURE_SIM_CORE_MACROS_SVH
`define FLOW_LINE_BLOCKING_DEPARTURE_SIM_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define FLBD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define FLBD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/flbd_pkg.sv =====
package flbd_pkg;

  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int TIME_BITS_DEF     = 48;

  localparam int SERVICE_BITS  = 32;
  localparam int BUF_BITS      = 5;
  localparam int JOB_BITS      = 16;
  localparam int OUT_TIME_BITS = 48;
  localparam int RATE_BITS     = 32;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DIV_CNT_BITS  = $clog2(RATE_BITS);

  localparam logic [BUF_BITS-1:0] BUFFER_FIRST_RST  = 5'd10;
  localparam logic [BUF_BITS-1:0] BUFFER_SECOND_RST = 5'd10;
  localparam logic [JOB_BITS-1:0] TOTAL_JOBS_RST    = 16'd2050;
  localparam logic [JOB_BITS-1:0] WARMUP_JOBS_RST   = 16'd2000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BUFFER_FIRST,
    REG_BUFFER_SECOND,
    REG_TOTAL_JOBS,
    REG_WARMUP_JOBS
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_TWO,
    ST_THREE,
    ST_SPAN,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic step_one;
    logic step_two;
    logic step_three;
    logic step_span;
    logic step_check;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_done;
    logic need_div;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== hw/rtl/flbd_div.sv =====
module flbd_div
  import flbd_pkg::*;
#(
  parameter int DIVISOR_BITS = TIME_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic [JOB_BITS-1:0]     dividend_i,
  input  logic [DIVISOR_BITS-1:0] divisor_i,
  output logic [RATE_BITS-1:0]    quotient_o
);

  logic [DIVISOR_BITS-1:0] rem_q, rem_d;
  logic [RATE_BITS-1:0]    quo_q;
  logic [DIVISOR_BITS:0]   shifted;
  logic [DIVISOR_BITS:0]   diff;
  logic                    ge;

  // one restoring step per cycle while step_i is high, remainder stays below the divisor
  always_comb begin
    shifted = {rem_q, 1'b0};
    diff    = shifted - {1'b0, divisor_i};
    ge      = (shifted >= {1'b0, divisor_i});
    rem_d   = ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIVISOR_BITS'(dividend_i);
      quo_q <= '0;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[RATE_BITS-2:0], ge};
    end
  end

  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/flbd_ctrl.sv =====
module flbd_ctrl
  import flbd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e                  state_q, state_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_ONE;
        end
      end
      ST_ONE: begin
        cmd_o.step_one = 1'b1;
        state_d        = ST_TWO;
      end
      ST_TWO: begin
        cmd_o.step_two = 1'b1;
        state_d        = ST_THREE;
      end
      ST_THREE: begin
        cmd_o.step_three = 1'b1;
        state_d          = status_i.run_done ? ST_SPAN : ST_OUT;
      end
      ST_SPAN: begin
        cmd_o.step_span = 1'b1;
        state_d         = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.step_check = 1'b1;
        if (status_i.need_div) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_BITS'(RATE_BITS - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/flbd_datapath.sv =====
module flbd_datapath
  import flbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [SERVICE_BITS-1:0]  service_first_i,
  input  logic [SERVICE_BITS-1:0]  service_second_i,
  input  logic [SERVICE_BITS-1:0]  service_third_i,
  input  ctrl_cmd_t                cmd_i,
  output ctrl_status_t             status_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [JOB_BITS-1:0]      job_number_o,
  output logic [OUT_TIME_BITS-1:0] depart_first_o,
  output logic [OUT_TIME_BITS-1:0] depart_second_o,
  output logic [OUT_TIME_BITS-1:0] depart_third_o,
  output logic [RATE_BITS-1:0]     rate_out_o,
  output logic                     run_done_o
);

  localparam int SLOT_BITS = $clog2(HISTORY_DEPTH);
  localparam int LAG_BITS  = SLOT_BITS + 1;
  localparam logic [LAG_BITS-1:0]  DEPTH_LAG = LAG_BITS'(HISTORY_DEPTH);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(HISTORY_DEPTH - 1);
  localparam logic [JOB_BITS-1:0]  DEPTH_JOB = JOB_BITS'(HISTORY_DEPTH);

  // configuration
  logic [BUF_BITS-1:0] buf_first_q, buf_second_q;
  logic [JOB_BITS-1:0] total_q, warm_q;

  // run state
  logic [TIME_BITS-1:0] last_first_q;
  logic [JOB_BITS-1:0]  count_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic [TIME_BITS-1:0] warm_dep_q;
  logic                 run_done_q;
  logic                 out_valid_q;

  // per job
  logic [SERVICE_BITS-1:0] t1_q, t2_q, t3_q;
  logic [JOB_BITS-1:0]     n_q;
  logic [SLOT_BITS-1:0]    cur_slot_q;
  logic                    z1_q, z2_q, prev_zero_q;
  logic [TIME_BITS-1:0]    prev2_q, lag2_q, prev3_q, lag3_q;
  logic [TIME_BITS-1:0]    d1_q, d2_q, d3_q;
  logic [TIME_BITS-1:0]    span_q;
  logic [JOB_BITS-1:0]     jobs_q;
  logic                    warm_lt_q, need_div_q;
  logic [RATE_BITS-1:0]    rate_q;

  logic [TIME_BITS-1:0] hist_second_mem [HISTORY_DEPTH];
  logic [TIME_BITS-1:0] hist_third_mem  [HISTORY_DEPTH];

  logic [JOB_BITS-1:0]  n_d;
  logic [SLOT_BITS-1:0] cur_slot_d;
  logic [LAG_BITS-1:0]  lag1, lag2, cur_ext, lag1_ext, lag2_ext;
  logic [SLOT_BITS-1:0] lag1_slot, lag2_slot;
  logic                 z1_d, z2_d;

  logic [TIME_BITS:0]   sum1, sum2, sum3;
  logic [TIME_BITS-1:0] s1, s2, prev2m, prev3m, a2, a3;
  logic [TIME_BITS-1:0] d1_d, d2_d, d3_d;
  logic                 done_now, need_div;
  logic [RATE_BITS-1:0] quotient;
  logic [63:0]          d1_wide, d2_wide, d3_wide;

  // slot bookkeeping for the next job
  always_comb begin
    n_d        = count_q + 1'b1;
    cur_slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
    lag1 = (JOB_BITS'(buf_first_q) >= DEPTH_JOB) ? DEPTH_LAG : LAG_BITS'(buf_first_q);
    lag2 = (JOB_BITS'(buf_second_q) >= DEPTH_JOB) ? DEPTH_LAG : LAG_BITS'(buf_second_q);
    cur_ext  = {1'b0, cur_slot_d};
    lag1_ext = (cur_ext >= lag1) ? cur_ext - lag1 : cur_ext + DEPTH_LAG - lag1;
    lag2_ext = (cur_ext >= lag2) ? cur_ext - lag2 : cur_ext + DEPTH_LAG - lag2;
    lag1_slot = lag1_ext[SLOT_BITS-1:0];
    lag2_slot = lag2_ext[SLOT_BITS-1:0];
    z1_d = (buf_first_q == '0) || (n_d <= JOB_BITS'(lag1));
    z2_d = (buf_second_q == '0) || (n_d <= JOB_BITS'(lag2));
  end

  // departure recursion, one stage per step
  always_comb begin
    sum1 = {1'b0, last_first_q} + (TIME_BITS+1)'(t1_q);
    s1   = sum1[TIME_BITS] ? '1 : sum1[TIME_BITS-1:0];
    d1_d = (!z1_q && (lag2_q > s1)) ? lag2_q : s1;

    prev2m = prev_zero_q ? '0 : prev2_q;
    a2     = (prev2m > d1_q) ? prev2m : d1_q;
    sum2   = {1'b0, a2} + (TIME_BITS+1)'(t2_q);
    s2     = sum2[TIME_BITS] ? '1 : sum2[TIME_BITS-1:0];
    d2_d   = (!z2_q && (lag3_q > s2)) ? lag3_q : s2;

    prev3m = prev_zero_q ? '0 : prev3_q;
    a3     = (prev3m > d2_q) ? prev3m : d2_q;
    sum3   = {1'b0, a3} + (TIME_BITS+1)'(t3_q);
    d3_d   = sum3[TIME_BITS] ? '1 : sum3[TIME_BITS-1:0];
  end

  assign done_now = run_done_q;
  assign need_div = warm_lt_q && (span_q > TIME_BITS'(jobs_q));

  assign status_o.run_done = done_now;
  assign status_o.need_div = need_div;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_first_q  <= BUFFER_FIRST_RST;
      buf_second_q <= BUFFER_SECOND_RST;
      total_q      <= TOTAL_JOBS_RST;
      warm_q       <= WARMUP_JOBS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BUFFER_FIRST:  buf_first_q  <= cfg_data_i[BUF_BITS-1:0];
        REG_BUFFER_SECOND: buf_second_q <= cfg_data_i[BUF_BITS-1:0];
        REG_TOTAL_JOBS:    total_q      <= cfg_data_i[JOB_BITS-1:0];
        REG_WARMUP_JOBS:   warm_q       <= cfg_data_i[JOB_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_first_q <= '0;
      count_q      <= '0;
      slot_q       <= '0;
      warm_dep_q   <= '0;
      run_done_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        run_done_q <= (n_d >= total_q);
      end
      if (cmd_i.step_three) begin
        last_first_q <= run_done_q ? '0 : d1_q;
        count_q      <= run_done_q ? '0 : n_q;
        slot_q       <= run_done_q ? '0 : cur_slot_q;
        if (n_q == warm_q) begin
          warm_dep_q <= d3_d;
        end
      end
      if (cmd_i.step_span) begin
        warm_dep_q <= '0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // history rings, read at job entry and written when the job finishes
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_three) begin
      hist_second_mem[cur_slot_q] <= d2_q;
      hist_third_mem[cur_slot_q]  <= d3_d;
    end
    if (cmd_i.accept) begin
      prev2_q <= hist_second_mem[slot_q];
      lag2_q  <= hist_second_mem[lag1_slot];
      prev3_q <= hist_third_mem[slot_q];
      lag3_q  <= hist_third_mem[lag2_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t1_q        <= service_first_i;
      t2_q        <= service_second_i;
      t3_q        <= service_third_i;
      n_q         <= n_d;
      cur_slot_q  <= cur_slot_d;
      z1_q        <= z1_d;
      z2_q        <= z2_d;
      prev_zero_q <= (count_q == '0);
    end
    if (cmd_i.step_one) begin
      d1_q <= d1_d;
    end
    if (cmd_i.step_two) begin
      d2_q <= d2_d;
    end
    if (cmd_i.step_three) begin
      d3_q <= d3_d;
    end
    if (cmd_i.step_span) begin
      span_q    <= d3_q - warm_dep_q;
      jobs_q    <= total_q - warm_q;
      warm_lt_q <= (warm_q < total_q);
    end
    if (cmd_i.step_check) begin
      need_div_q <= need_div;
      rate_q     <= warm_lt_q ? '1 : '0;
    end
  end

  flbd_div #(
    .DIVISOR_BITS(TIME_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .start_i   (cmd_i.step_check),
    .step_i    (cmd_i.div_step),
    .dividend_i(jobs_q),
    .divisor_i (span_q),
    .quotient_o(quotient)
  );

  assign d1_wide = 64'(d1_q);
  assign d2_wide = 64'(d2_q);
  assign d3_wide = 64'(d3_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      job_number_o    <= n_q;
      depart_first_o  <= d1_wide[OUT_TIME_BITS-1:0];
      depart_second_o <= d2_wide[OUT_TIME_BITS-1:0];
      depart_third_o  <= d3_wide[OUT_TIME_BITS-1:0];
      rate_out_o      <= run_done_q ? (need_div_q ? quotient : rate_q) : '0;
      run_done_o      <= run_done_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/flow_line_blocking_departure_sim_core.sv =====
// Three-stage flow line with blocking: each input word carries one job's three service
// times and yields one result word with the job's departure time from each stage. On its
// way to the output register a job steps through: the acceptance cycle reads the two
// history rings, one state for each stage's add-and-max, then the output load, which
// waits for a free output register. The final job of a run adds the span and check
// states to form the measured span and, when the quotient is in range, the bit-serial
// divider steps that produce the throughput. in_stall_o is high from acceptance until
// the result is loaded; the output register holds a waiting result while the next job
// is taken. Run state is cleared in-line on the final job, so no start-up pass is needed.
module flow_line_blocking_departure_sim_core
  import flbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SERVICE_BITS-1:0]  service_first_i,
  input  logic [SERVICE_BITS-1:0]  service_second_i,
  input  logic [SERVICE_BITS-1:0]  service_third_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [JOB_BITS-1:0]      job_number_o,
  output logic [OUT_TIME_BITS-1:0] depart_first_o,
  output logic [OUT_TIME_BITS-1:0] depart_second_o,
  output logic [OUT_TIME_BITS-1:0] depart_third_o,
  output logic [RATE_BITS-1:0]     rate_out_o,
  output logic                     run_done_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  flbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  flbd_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .service_first_i (service_first_i),
    .service_second_i(service_second_i),
    .service_third_i (service_third_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .job_number_o    (job_number_o),
    .depart_first_o  (depart_first_o),
    .depart_second_o (depart_second_o),
    .depart_third_o  (depart_third_o),
    .rate_out_o      (rate_out_o),
    .run_done_o      (run_done_o)
  );

endmodule

// ===== hw/rtl/flbd_checker.sv =====
`include "flow_line_blocking_departure_sim_core_macros.svh"

module flbd_checker
  import flbd_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [JOB_BITS-1:0]      job_number_o,
  input logic [OUT_TIME_BITS-1:0] depart_third_o,
  input logic [RATE_BITS-1:0]     rate_out_o,
  input logic                     run_done_o
);

  `FLBD_ASSERT(a_out_hold, clk_i, rst_ni,
               out_valid_o && out_stall_i |=> out_valid_o,
               "result word dropped while stalled")
  `FLBD_ASSERT(a_out_stable, clk_i, rst_ni,
               out_valid_o && out_stall_i |=> $stable(job_number_o) &&
               $stable(depart_third_o) && $stable(rate_out_o),
               "stalled result word changed")
  `FLBD_ASSERT(a_one_job, clk_i, rst_ni,
               in_valid_i && !in_stall_o |=> in_stall_o,
               "second job taken while one is in work")
  `FLBD_ASSERT_NEVER(a_rate_only_done, clk_i, rst_ni,
                     out_valid_o && !run_done_o && (rate_out_o != 0),
                     "rate shown on a job that is not final")
  `FLBD_ASSERT_NEVER(a_job_nonzero, clk_i, rst_ni,
                     out_valid_o && (job_number_o == 0),
                     "job number zero in result word")

endmodule

bind flow_line_blocking_departure_sim_core flbd_checker u_flbd_checker (.*);
